@@ design/rtcp_pkg.sv @@
// Shared types, constants and helpers for the region tile copy planner.
// No dependencies; every other design file imports this package.
package rtcp_pkg;

    localparam int COORD_W = 20;
    localparam int INDEX_W = 40;
    localparam int BYTES_W = 47;
    localparam int SPP_W   = 7;

    // APB register file
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_LEVEL_WIDTH  = 3'd0;
    localparam logic [2:0] REG_LEVEL_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TILE_WIDTH   = 3'd2;
    localparam logic [2:0] REG_TILE_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_TILED_MODE   = 3'd4;
    localparam logic [2:0] REG_SAMPLES      = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_TILE    = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_SPAN    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // Plan queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef struct packed {
        logic [COORD_W-1:0] level_width;
        logic [COORD_W-1:0] level_height;
        logic [COORD_W-1:0] tile_w;
        logic [COORD_W-1:0] tile_h;
        logic               tiled_mode;
        logic [SPP_W-1:0]   samples;
    } t_cfg;

    typedef struct packed {
        logic               whole_level;
        logic [COORD_W-1:0] rect_x;
        logic [COORD_W-1:0] rect_y;
        logic [COORD_W-1:0] region_width;
        logic [COORD_W-1:0] region_height;
    } t_req;

    typedef struct packed {
        logic [COORD_W-1:0] tile_col;
        logic [COORD_W-1:0] tile_row;
        logic [INDEX_W-1:0] tile_index;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [COORD_W-1:0] copy_width;
        logic [COORD_W-1:0] copy_height;
        logic [BYTES_W-1:0] read_bytes;
        logic               last;
        logic [1:0]         status;
    } t_desc;

    // One classified request, ready for the tile walk
    typedef struct packed {
        logic [1:0]         status;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        logic [COORD_W-1:0] lx;
        logic [COORD_W-1:0] ly;
        logic [COORD_W-1:0] left0;
        logic [COORD_W-1:0] top0;
        logic [COORD_W-1:0] across;
        logic [INDEX_W-1:0] row_base;
        logic [BYTES_W-1:0] rbytes;
    } t_plan;

    // A tile dimension of zero counts as one
    function automatic logic [COORD_W-1:0] eff_dim(input logic [COORD_W-1:0] v);
        eff_dim = (v == '0) ? COORD_W'(1) : v;
    endfunction

endpackage

@@ design/region_tile_copy_planner.sv @@
// Top level of the region tile copy planner: APB register file, front end,
// plan queue and tile walker. Depends on rtcp_pkg and all rtcp_ modules.
//
// Takes one region request (whole level or a pixel rectangle) per input
// transaction and emits one copy descriptor per tile or strip that the
// rectangle, clamped to the level, touches, in row-major order; the final
// descriptor of a request carries last. A rectangle outside the level, an
// empty rectangle, or one spanning more than MAX_SPAN tiles on either axis
// gives a single status transaction instead. After accepting a request the
// front end stalls the request channel until it has pushed the plan; an outside
// or empty request skips the division rounds and the multiplies, a too large
// span skips the last round and the multiplies, and the stall lasts longer
// while the plan queue is full. Each division round divides x and y in
// parallel into 20 radix-2 quotient bits and hands the result over through
// the registered done flag of the dividers; a full plan needs the classify
// state, three rounds, the multiply states and the push state, so the dividers
// set the pace. The walker takes a plan while idle and then emits one
// descriptor per unstalled cycle; a two-entry plan queue lets the front end plan
// the next request while the walker is still emitting. Configuration registers
// sit at byte addresses 4*i: level width, level height, tile width, tile height,
// tiled mode, samples per pixel; write them only while the block is idle.
module region_tile_copy_planner import rtcp_pkg::*; #(
    parameter int MAX_SPAN = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_req              i_in_data,
    // descriptor channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_desc             o_out_data,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    logic  q_push, q_full, q_pop, q_empty;
    t_plan front_plan, back_plan;

    // Register file: decode the word index, write on the access phase
    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_width  <= COORD_W'(1);
            r_cfg.level_height <= COORD_W'(1);
            r_cfg.tile_w       <= COORD_W'(256);
            r_cfg.tile_h       <= COORD_W'(256);
            r_cfg.tiled_mode   <= 1'b1;
            r_cfg.samples      <= SPP_W'(3);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LEVEL_WIDTH:  r_cfg.level_width  <= pwdata[COORD_W-1:0];
                REG_LEVEL_HEIGHT: r_cfg.level_height <= pwdata[COORD_W-1:0];
                REG_TILE_WIDTH:   r_cfg.tile_w       <= pwdata[COORD_W-1:0];
                REG_TILE_HEIGHT:  r_cfg.tile_h       <= pwdata[COORD_W-1:0];
                REG_TILED_MODE:   r_cfg.tiled_mode   <= pwdata[0];
                REG_SAMPLES:      r_cfg.samples      <= pwdata[SPP_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back: zero-extend each register, unmapped words read as zero
    always_comb begin
        unique case (reg_idx)
            REG_LEVEL_WIDTH:  prdata = DATA_W'(r_cfg.level_width);
            REG_LEVEL_HEIGHT: prdata = DATA_W'(r_cfg.level_height);
            REG_TILE_WIDTH:   prdata = DATA_W'(r_cfg.tile_w);
            REG_TILE_HEIGHT:  prdata = DATA_W'(r_cfg.tile_h);
            REG_TILED_MODE:   prdata = DATA_W'(r_cfg.tiled_mode);
            REG_SAMPLES:      prdata = DATA_W'(r_cfg.samples);
            default:          prdata = '0;
        endcase
    end

    // Classify the request and derive the tile span
    rtcp_front #(
        .MAX_SPAN (MAX_SPAN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_req   (i_in_data),
        .o_push  (q_push),
        .o_plan  (front_plan),
        .i_full  (q_full)
    );

    // Hold finished plans so each side stalls on its own
    rtcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_plan),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (back_plan),
        .o_empty (q_empty)
    );

    // Walk the tiles and drive the descriptor transactions
    rtcp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (q_empty),
        .i_plan  (back_plan),
        .o_pop   (q_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_desc  (o_out_data)
    );

endmodule

@@ design/rtcp_div.sv @@
// Restoring divider, one quotient bit per cycle, COORD_W-bit operands.
// Depends on rtcp_pkg.
module rtcp_div import rtcp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COORD_W-1:0] i_dividend,
    input  logic [COORD_W-1:0] i_divisor,
    output logic               o_done,
    output logic [COORD_W-1:0] o_quo,
    output logic [COORD_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(COORD_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [COORD_W-1:0] r_quo;
    logic [COORD_W-1:0] r_rem;
    logic [COORD_W-1:0] r_div;
    logic [COORD_W:0]   shifted;
    logic [COORD_W:0]   diff;
    logic               ge;

    assign shifted = {r_rem, r_quo[COORD_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign ge      = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(COORD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[COORD_W-2:0], ge};
            r_rem <= ge ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ design/rtcp_front.sv @@
// Front end: accepts a region request, classifies it and works out the tile
// span, row index base and read size. Depends on rtcp_pkg and rtcp_div.
module rtcp_front import rtcp_pkg::*; #(
    parameter int MAX_SPAN = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_req  i_req,
    output logic  o_push,
    output t_plan o_plan,
    input  logic  i_full
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_CLASS = 3'd1;
    localparam logic [2:0] F_DIV_A = 3'd2;
    localparam logic [2:0] F_DIV_B = 3'd3;
    localparam logic [2:0] F_DIV_C = 3'd4;
    localparam logic [2:0] F_MUL1  = 3'd5;
    localparam logic [2:0] F_MUL2  = 3'd6;
    localparam logic [2:0] F_PUSH  = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [COORD_W-1:0] r_rx, r_ry, r_rw, r_rh;
    logic [COORD_W-1:0] r_end_x, r_end_y;
    logic [COORD_W-1:0] r_fx, r_fy, r_lx, r_ly, r_left0, r_top0, r_across;
    logic [INDEX_W-1:0] r_area, r_row_base;
    logic [BYTES_W-1:0] r_rbytes;
    logic [1:0]         r_status;

    logic [COORD_W-1:0] tw_eff, th_eff;
    logic [COORD_W:0]   sum_x, sum_y;
    logic [COORD_W-1:0] clamp_x, clamp_y;
    logic               outside, empty, span_big, accept, div_done;
    logic               div_start;
    logic [COORD_W-1:0] div_num_x, div_num_y;
    logic [COORD_W-1:0] quo_x, rem_x, quo_y, rem_y;
    logic               done_x, done_y;

    assign tw_eff = eff_dim(i_cfg.tile_w);
    assign th_eff = eff_dim(i_cfg.tile_h);

    // Clamp the rectangle to the level
    assign sum_x   = {1'b0, r_rx} + {1'b0, r_rw};
    assign sum_y   = {1'b0, r_ry} + {1'b0, r_rh};
    assign clamp_x = (sum_x > {1'b0, i_cfg.level_width})  ? i_cfg.level_width
                                                          : sum_x[COORD_W-1:0];
    assign clamp_y = (sum_y > {1'b0, i_cfg.level_height}) ? i_cfg.level_height
                                                          : sum_y[COORD_W-1:0];
    assign outside = (r_rx >= i_cfg.level_width) || (r_ry >= i_cfg.level_height);
    assign empty   = (clamp_x == r_rx) || (clamp_y == r_ry);

    assign div_done = done_x && done_y;
    assign span_big = ((quo_x - r_fx) >= COORD_W'(MAX_SPAN)) ||
                      ((quo_y - r_fy) >= COORD_W'(MAX_SPAN));
    assign accept   = i_valid && (r_state == F_IDLE);

    rtcp_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num_x),
        .i_divisor  (tw_eff),
        .o_done     (done_x),
        .o_quo      (quo_x),
        .o_rem      (rem_x)
    );

    rtcp_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num_y),
        .i_divisor  (th_eff),
        .o_done     (done_y),
        .o_quo      (quo_y),
        .o_rem      (rem_y)
    );

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num_x = r_rx;
        div_num_y = r_ry;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) n_state = F_CLASS;
            end
            F_CLASS: begin
                if (outside || empty) begin
                    n_state = F_PUSH;
                end else begin
                    div_start = 1'b1;
                    n_state   = F_DIV_A;
                end
            end
            F_DIV_A: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_num_x = r_end_x - COORD_W'(1);
                    div_num_y = r_end_y - COORD_W'(1);
                    n_state   = F_DIV_B;
                end
            end
            F_DIV_B: begin
                if (div_done) begin
                    if (span_big) begin
                        n_state = F_PUSH;
                    end else begin
                        div_start = 1'b1;
                        div_num_x = i_cfg.level_width;
                        div_num_y = i_cfg.level_height;
                        n_state   = F_DIV_C;
                    end
                end
            end
            F_DIV_C: begin
                if (div_done) n_state = F_MUL1;
            end
            F_MUL1: n_state = F_MUL2;
            F_MUL2: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rx <= i_req.whole_level ? '0 : i_req.rect_x;
            r_ry <= i_req.whole_level ? '0 : i_req.rect_y;
            r_rw <= i_req.whole_level ? i_cfg.level_width  : i_req.region_width;
            r_rh <= i_req.whole_level ? i_cfg.level_height : i_req.region_height;
        end
        if (r_state == F_CLASS) begin
            r_end_x <= clamp_x;
            r_end_y <= clamp_y;
            r_status <= outside ? ST_OUTSIDE : (empty ? ST_EMPTY : ST_TILE);
        end
        if (r_state == F_DIV_A && div_done) begin
            r_fx    <= quo_x;
            r_fy    <= quo_y;
            r_left0 <= r_rx - rem_x;
            r_top0  <= r_ry - rem_y;
        end
        if (r_state == F_DIV_B && div_done) begin
            r_lx <= quo_x;
            r_ly <= quo_y;
            if (span_big) r_status <= ST_SPAN;
        end
        if (r_state == F_DIV_C && div_done) begin
            r_across <= quo_x + COORD_W'(rem_x != '0);
        end
        if (r_state == F_MUL1) begin
            r_row_base <= INDEX_W'(r_fy) * INDEX_W'(r_across);
            r_area     <= INDEX_W'(tw_eff) * INDEX_W'(th_eff);
        end
        if (r_state == F_MUL2) begin
            r_rbytes <= BYTES_W'(r_area) * BYTES_W'(i_cfg.samples);
        end
    end

    assign o_stall = (r_state != F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;

    always_comb begin
        o_plan.status   = r_status;
        o_plan.rx       = r_rx;
        o_plan.ry       = r_ry;
        o_plan.end_x    = r_end_x;
        o_plan.end_y    = r_end_y;
        o_plan.fx       = r_fx;
        o_plan.fy       = r_fy;
        o_plan.lx       = r_lx;
        o_plan.ly       = r_ly;
        o_plan.left0    = r_left0;
        o_plan.top0     = r_top0;
        o_plan.across   = r_across;
        o_plan.row_base = r_row_base;
        o_plan.rbytes   = r_rbytes;
    end

endmodule

@@ design/rtcp_queue.sv @@
// Short plan queue between the front end and the tile walker.
// Depends on rtcp_pkg.
module rtcp_queue import rtcp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_plan i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_plan o_data,
    output logic  o_empty
);

    t_plan                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_AW:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

@@ design/rtcp_back.sv @@
// Tile walker: pops a plan and emits its descriptors in row-major order
// through an output register. Depends on rtcp_pkg.
module rtcp_back import rtcp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_empty,
    input  t_plan i_plan,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_stall,
    output t_desc o_desc
);

    localparam logic B_IDLE = 1'b0;
    localparam logic B_RUN  = 1'b1;

    logic               r_state;
    t_plan              r_plan;
    logic [COORD_W-1:0] r_tx, r_ty, r_left, r_top;
    logic [INDEX_W-1:0] r_row_idx;
    logic               r_out_valid;
    t_desc              r_out;

    logic [COORD_W-1:0] tw_eff, th_eff;
    logic [COORD_W:0]   right_sum, bottom_sum;
    logic [COORD_W-1:0] right, bottom, il, it, ir, ib;
    logic               adv, produce, end_col, end_row, is_flag;
    t_desc              desc;

    assign tw_eff = eff_dim(i_cfg.tile_w);
    assign th_eff = eff_dim(i_cfg.tile_h);

    // Tile extent, cut at the level edge, then its overlap with the region
    assign right_sum  = {1'b0, r_left} + {1'b0, tw_eff};
    assign bottom_sum = {1'b0, r_top}  + {1'b0, th_eff};
    assign right  = (right_sum  > {1'b0, i_cfg.level_width})  ? i_cfg.level_width
                                                              : right_sum[COORD_W-1:0];
    assign bottom = (bottom_sum > {1'b0, i_cfg.level_height}) ? i_cfg.level_height
                                                              : bottom_sum[COORD_W-1:0];
    assign il = (r_left > r_plan.rx) ? r_left : r_plan.rx;
    assign it = (r_top  > r_plan.ry) ? r_top  : r_plan.ry;
    assign ir = (right  < r_plan.end_x) ? right  : r_plan.end_x;
    assign ib = (bottom < r_plan.end_y) ? bottom : r_plan.end_y;

    assign end_col = (r_tx == r_plan.lx);
    assign end_row = (r_ty == r_plan.ly);
    assign is_flag = (r_plan.status != ST_TILE);

    always_comb begin
        if (is_flag) begin
            desc        = '0;
            desc.last   = 1'b1;
            desc.status = r_plan.status;
        end else begin
            desc.tile_col    = r_tx;
            desc.tile_row    = r_ty;
            desc.tile_index  = i_cfg.tiled_mode ? (r_row_idx + INDEX_W'(r_tx))
                                                : INDEX_W'(r_ty);
            desc.src_x       = il - r_left;
            desc.src_y       = it - r_top;
            desc.dest_x      = il - r_plan.rx;
            desc.dest_y      = it - r_plan.ry;
            desc.copy_width  = ir - il;
            desc.copy_height = ib - it;
            desc.read_bytes  = r_plan.rbytes;
            desc.last        = end_col && end_row;
            desc.status      = ST_TILE;
        end
    end

    assign adv     = !r_out_valid || !i_stall;
    assign produce = (r_state == B_RUN) && adv;
    assign o_pop   = (r_state == B_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) r_out_valid <= produce;
            if (o_pop) begin
                r_state <= B_RUN;
            end else if (produce && desc.last) begin
                r_state <= B_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_plan    <= i_plan;
            r_tx      <= i_plan.fx;
            r_ty      <= i_plan.fy;
            r_left    <= i_plan.left0;
            r_top     <= i_plan.top0;
            r_row_idx <= i_plan.row_base;
        end else if (produce) begin
            if (end_col) begin
                r_tx      <= r_plan.fx;
                r_left    <= r_plan.left0;
                r_ty      <= r_ty + COORD_W'(1);
                r_top     <= r_top + th_eff;
                r_row_idx <= r_row_idx + INDEX_W'(r_plan.across);
            end else begin
                r_tx   <= r_tx + COORD_W'(1);
                r_left <= r_left + tw_eff;
            end
        end
        if (produce) r_out <= desc;
    end

    assign o_valid = r_out_valid;
    assign o_desc  = r_out;

endmodule
